// File: hw/rtl/tpi_pkg.sv
package tpi_pkg;

    // Widths of the timestamp, the configuration registers and the config port
    localparam int TS_W   = 34;
    localparam int LEN_W  = 16;
    localparam int UNIT_W = 3;
    localparam int CFG_W  = 16;

    // Register indexes on the configuration port
    localparam logic CFG_UNIT   = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // Unit codes
    localparam logic [UNIT_W-1:0] UNIT_SEC   = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_MIN   = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_HOUR  = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_DAY   = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_WEEK  = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_MONTH = 3'd5;
    localparam logic [UNIT_W-1:0] UNIT_YEAR  = 3'd6;
    localparam logic [UNIT_W-1:0] UNIT_NONE  = 3'd7;

    // Time constants
    localparam int SECS_MIN   = 60;
    localparam int SECS_HOUR  = 3600;
    localparam int SECS_DAY   = 86400;
    localparam int WEEK_OFS   = 3 * 86400;
    localparam int SECS_WEEK  = 7 * 86400;
    localparam int MONTHS_YR  = 12;

    // Reciprocals for the timestamp quotients, scaled by 2^TS_W
    localparam int RCP_W = 29;
    localparam int C_W   = 20;
    localparam logic [RCP_W-1:0] RCP_MIN  = RCP_W'((64'd1 << TS_W) / 64'd60);
    localparam logic [RCP_W-1:0] RCP_HOUR = RCP_W'((64'd1 << TS_W) / 64'd3600);
    localparam logic [RCP_W-1:0] RCP_DAY  = RCP_W'((64'd1 << TS_W) / 64'd86400);
    localparam logic [RCP_W-1:0] RCP_WEEK = RCP_W'((64'd1 << TS_W) / 64'd604800);

    // Calendar constants; small reciprocals are scaled by 2^CAL_SH
    localparam int CAL_SH     = 20;
    localparam int DAYS_SHIFT = 719468;
    localparam int DAYS_ERA   = 146097;
    localparam int DAYS_CENT  = 36524;
    localparam int DAYS_4Y    = 1460;
    localparam int DAYS_YEAR  = 365;
    localparam int RCP_4Y     = (1 << CAL_SH) / 1460;
    localparam int RCP_YEAR   = (1 << CAL_SH) / 365;
    localparam int BASE_YEAR  = 1900;

    // Pipeline depths
    localparam int CDIV_LAT  = 3;
    localparam int CIVIL_LAT = 13;
    localparam int LDIV_LAT  = TS_W;
    localparam int TOTAL_LAT = 1 + CDIV_LAT + CIVIL_LAT + LDIV_LAT + 1;

    // Word handed between the pipeline sections
    typedef struct packed {
        logic [TS_W-1:0]   count;
        logic [UNIT_W-1:0] unit;
        logic [LEN_W-1:0]  length;
    } t_item;

    // Calendar working set carried down the civil pipeline
    typedef struct packed {
        t_item       item;
        logic [19:0] z;
        logic [2:0]  era;
        logic [17:0] doe;
        logic [2:0]  cen;
        logic        last;
        logic [29:0] prd;
        logic [8:0]  qe;
        logic [17:0] qc;
        logic [17:0] num;
        logic [8:0]  yoe;
        logic [17:0] t1;
        logic [8:0]  doy;
        logic [3:0]  mp;
        logic [3:0]  mon;
        logic [11:0] yr;
    } t_cal;

    // One step of the length divider
    typedef struct packed {
        logic [TS_W-1:0]  q;
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] len;
    } t_div;

endpackage

// File: hw/rtl/tpi_cdiv.sv
module tpi_cdiv
    import tpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TS_W-1:0]   i_ts,
    input  logic [UNIT_W-1:0] i_unit,
    input  logic [LEN_W-1:0]  i_length,
    output logic              o_valid,
    output t_item             o_item
);

    logic                   r1_v, r2_v, r3_v;
    logic [TS_W-1:0]        r1_x, r2_x, r1_ts, r2_ts;
    logic [UNIT_W-1:0]      r1_unit, r2_unit;
    logic [LEN_W-1:0]       r1_len, r2_len;
    logic [C_W-1:0]         r1_c, r2_c;
    logic [TS_W+RCP_W-1:0]  r1_prd;
    logic [TS_W-1:0]        r2_q0, r2_qc;
    t_item                  r3_item;

    logic [TS_W-1:0]        n_x;
    logic [C_W-1:0]         n_c;
    logic [RCP_W-1:0]       n_rcp;
    logic [TS_W-1:0]        n_q0, n_rr, n_q;
    logic [TS_W-1:0]        n_count;

    // Pick the divisor constant and its reciprocal
    always_comb begin
        n_x   = i_ts;
        n_c   = C_W'(1);
        n_rcp = '0;
        case (i_unit)
            UNIT_MIN: begin
                n_c   = C_W'(SECS_MIN);
                n_rcp = RCP_MIN;
            end
            UNIT_HOUR: begin
                n_c   = C_W'(SECS_HOUR);
                n_rcp = RCP_HOUR;
            end
            UNIT_DAY, UNIT_MONTH, UNIT_YEAR: begin
                n_c   = C_W'(SECS_DAY);
                n_rcp = RCP_DAY;
            end
            UNIT_WEEK: begin
                n_c   = C_W'(SECS_WEEK);
                n_rcp = RCP_WEEK;
                n_x   = (i_ts >= TS_W'(WEEK_OFS)) ? i_ts - TS_W'(WEEK_OFS) : '0;
            end
            default: begin
                n_c   = C_W'(1);
                n_rcp = '0;
            end
        endcase
    end

    // Estimate quotient, then its back product, then correct by one
    always_comb begin
        n_q0 = TS_W'(r1_prd >> TS_W);
        n_rr = r2_x - r2_qc;
        n_q  = r2_q0 + ((n_rr >= TS_W'(r2_c)) ? TS_W'(1) : TS_W'(0));
        case (r2_unit)
            UNIT_SEC:                       n_count = r2_ts;
            UNIT_MIN, UNIT_HOUR, UNIT_DAY,
            UNIT_WEEK, UNIT_MONTH, UNIT_YEAR: n_count = n_q;
            default:                        n_count = '0;
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r1_x    <= n_x;
        r1_ts   <= i_ts;
        r1_unit <= i_unit;
        r1_len  <= i_length;
        r1_c    <= n_c;
        r1_prd  <= (TS_W+RCP_W)'(n_x) * (TS_W+RCP_W)'(n_rcp);
        r2_x    <= r1_x;
        r2_ts   <= r1_ts;
        r2_unit <= r1_unit;
        r2_len  <= r1_len;
        r2_c    <= r1_c;
        r2_q0   <= n_q0;
        r2_qc   <= TS_W'((TS_W+C_W)'(n_q0) * (TS_W+C_W)'(r1_c));
        r3_item.count  <= n_count;
        r3_item.unit   <= r2_unit;
        r3_item.length <= r2_len;
    end

    assign o_valid = r3_v;
    assign o_item  = r3_item;

    // Estimate is never above the true quotient
    a_est_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> r2_qc <= r2_x)
        else $error("quotient estimate too large");

    // Remainder before correction stays below twice the divisor
    a_rem_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v && r2_c != C_W'(1) |-> (n_rr < TS_W'(r2_c) * TS_W'(2)))
        else $error("quotient estimate too small");

    // Undefined unit code counts nothing
    a_unit7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v && r3_item.unit == UNIT_NONE |-> r3_item.count == '0)
        else $error("undefined unit gave a count");

endmodule

// File: hw/rtl/tpi_civil.sv
module tpi_civil
    import tpi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    t_cal                 r_st [CIVIL_LAT];
    t_cal                 n_st [CIVIL_LAT];
    logic [CIVIL_LAT-1:0] r_v;

    // Calendar steps, one per stage
    always_comb begin
        logic [17:0] rn;
        logic [8:0]  dq;
        logic [1:0]  cent;
        logic [11:0] v;
        logic [11:0] yy;

        // Shift days to a March-based era count
        n_st[0]      = '0;
        n_st[0].item = i_item;
        n_st[0].z    = 20'(i_item.count[17:0]) + 20'(DAYS_SHIFT);
        n_st[0].era  = '0;
        for (int k = 1; k <= 6; k++) begin
            if (n_st[0].z >= 20'(k * DAYS_ERA)) begin
                n_st[0].era = n_st[0].era + 3'd1;
            end
        end

        // Day of era
        n_st[1]     = r_st[0];
        n_st[1].doe = 18'(r_st[0].z - 20'(r_st[0].era) * 20'(DAYS_ERA));

        // Century and four-year terms
        n_st[2]      = r_st[1];
        n_st[2].cen  = '0;
        for (int k = 1; k <= 4; k++) begin
            if (r_st[1].doe >= 18'(k * DAYS_CENT)) begin
                n_st[2].cen = n_st[2].cen + 3'd1;
            end
        end
        n_st[2].last = (r_st[1].doe == 18'(DAYS_ERA - 1));
        n_st[2].prd  = 30'(r_st[1].doe) * 30'(RCP_4Y);

        n_st[3]    = r_st[2];
        n_st[3].qe = 9'(r_st[2].prd >> CAL_SH);
        n_st[3].qc = 18'(18'(n_st[3].qe) * 18'(DAYS_4Y));

        n_st[4]     = r_st[3];
        rn          = r_st[3].doe - r_st[3].qc;
        dq          = r_st[3].qe + ((rn >= 18'(DAYS_4Y)) ? 9'd1 : 9'd0);
        n_st[4].num = r_st[3].doe - 18'(dq) + 18'(r_st[3].cen) - 18'(r_st[3].last);

        // Year of era
        n_st[5]     = r_st[4];
        n_st[5].prd = 30'(r_st[4].num) * 30'(RCP_YEAR);

        n_st[6]    = r_st[5];
        n_st[6].qe = 9'(r_st[5].prd >> CAL_SH);
        n_st[6].qc = 18'(18'(n_st[6].qe) * 18'(DAYS_YEAR));

        n_st[7]     = r_st[6];
        n_st[7].yoe = r_st[6].qe
                    + ((r_st[6].num - r_st[6].qc >= 18'(DAYS_YEAR)) ? 9'd1 : 9'd0);

        // Day of year
        n_st[8]    = r_st[7];
        cent       = 2'((r_st[7].yoe >= 9'd100) ? 1 : 0)
                   + 2'((r_st[7].yoe >= 9'd200) ? 1 : 0)
                   + 2'((r_st[7].yoe >= 9'd300) ? 1 : 0);
        n_st[8].t1 = 18'(r_st[7].yoe) * 18'(DAYS_YEAR)
                   + 18'(r_st[7].yoe >> 2) - 18'(cent);

        n_st[9]     = r_st[8];
        n_st[9].doy = 9'(r_st[8].doe - r_st[8].t1);

        // March-based month
        n_st[10]    = r_st[9];
        v           = 12'(r_st[9].doy) * 12'd5 + 12'd2;
        n_st[10].mp = '0;
        for (int k = 1; k <= 11; k++) begin
            if (v >= 12'(153 * k)) begin
                n_st[10].mp = n_st[10].mp + 4'd1;
            end
        end

        // Civil month and year
        n_st[11]     = r_st[10];
        n_st[11].mon = (r_st[10].mp < 4'd10) ? r_st[10].mp + 4'd3 : r_st[10].mp - 4'd9;
        n_st[11].yr  = 12'(r_st[10].yoe) + 12'(r_st[10].era) * 12'd400
                     + ((n_st[11].mon <= 4'd2) ? 12'd1 : 12'd0);

        // Select the final unit count
        n_st[12] = r_st[11];
        yy       = r_st[11].yr - 12'(BASE_YEAR);
        case (r_st[11].item.unit)
            UNIT_MONTH: n_st[12].item.count = TS_W'(yy) * TS_W'(MONTHS_YR)
                                            + TS_W'(r_st[11].mon) - TS_W'(1);
            UNIT_YEAR:  n_st[12].item.count = TS_W'(yy);
            default:    n_st[12].item.count = r_st[11].item.count;
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CIVIL_LAT-2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CIVIL_LAT; k++) begin
            r_st[k] <= n_st[k];
        end
    end

    assign o_valid = r_v[CIVIL_LAT-1];
    assign o_item  = r_st[CIVIL_LAT-1].item;

    // Month of year stays in range
    a_mon_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[11] |-> r_st[11].mon >= 4'd1 && r_st[11].mon <= 4'd12)
        else $error("month out of range");

    // Day of year stays within a year
    a_doy_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[9] |-> r_st[9].doy <= 9'd365)
        else $error("day of year out of range");

    // Non-calendar units pass their count through unchanged
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[11] && r_st[11].item.unit != UNIT_MONTH && r_st[11].item.unit != UNIT_YEAR
        |=> r_st[12].item.count == $past(r_st[11].item.count))
        else $error("count altered for a non-calendar unit");

endmodule

// File: hw/rtl/tpi_ldiv.sv
module tpi_ldiv
    import tpi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_item           i_item,
    output logic            o_valid,
    output logic [TS_W-1:0] o_index,
    output logic            o_error
);

    t_div              r_dv [LDIV_LAT];
    t_div              n_dv [LDIV_LAT];
    logic [LDIV_LAT-1:0] r_v;

    // One quotient bit per stage, most significant first
    always_comb begin
        t_div        cur;
        logic [LEN_W:0] trial;
        logic        ge;

        for (int k = 0; k < LDIV_LAT; k++) begin
            if (k == 0) begin
                cur.q   = i_item.count;
                cur.rem = '0;
                cur.len = i_item.length;
            end else begin
                cur = r_dv[k-1];
            end
            trial       = {cur.rem, cur.q[TS_W-1]};
            ge          = (trial >= {1'b0, cur.len});
            n_dv[k].len = cur.len;
            n_dv[k].rem = ge ? LEN_W'(trial - {1'b0, cur.len}) : trial[LEN_W-1:0];
            n_dv[k].q   = {cur.q[TS_W-2:0], ge};
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LDIV_LAT-2:0], i_valid};
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LDIV_LAT; k++) begin
            r_dv[k] <= n_dv[k];
        end
    end

    assign o_valid = r_v[LDIV_LAT-1];
    assign o_error = (r_dv[LDIV_LAT-1].len == '0);
    assign o_index = o_error ? '0 : r_dv[LDIV_LAT-1].q;

    // Final remainder stays below a nonzero divisor
    a_rem_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |-> r_dv[LDIV_LAT-1].rem < r_dv[LDIV_LAT-1].len)
        else $error("remainder not below divisor");

    // Divisor travels unchanged with its word
    a_len_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |=> r_dv[1].len == $past(r_dv[0].len))
        else $error("divisor changed in flight");

    // Divide by one returns the count itself
    a_div_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.length == LEN_W'(1) |-> ##(LDIV_LAT) o_index == $past(i_item.count, LDIV_LAT))
        else $error("divide by one altered the count");

endmodule

// File: hw/rtl/timestamp_to_period_index.sv
// Timestamp to period index.
// Input channel: a command word is taken on each rising edge with start high
// and busy low; i_unix_seconds carries seconds since 1970-01-01 UTC.
// busy stays low, so one word can be taken every clock cycle.
// Output channel: o_valid is high for one cycle with o_period_index and
// o_zero_length_error; the receiver cannot stall, and none is needed since
// every word moves one stage per cycle.
// From accept to o_valid a word passes one input register, three stages of
// constant division, thirteen calendar stages, a 34-stage restoring divider
// by the period length (one quotient bit per stage) and one output register.
// Throughput is one word per cycle.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 period_unit, 1 period_length); write only while no word is in flight.
// Each word takes the unit and length in force when it was accepted.
// Reset (i_rst_n low, synchronous) drops all words in flight and sets
// period_unit to seconds and period_length to one.
module timestamp_to_period_index
    import tpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [TS_W-1:0]  i_unix_seconds,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_valid,
    output logic [TS_W-1:0]  o_period_index,
    output logic             o_zero_length_error
);

    logic [UNIT_W-1:0] r_unit;
    logic [LEN_W-1:0]  r_len;
    logic              r_in_v;
    logic [TS_W-1:0]   r_in_ts;
    logic [UNIT_W-1:0] r_in_unit;
    logic [LEN_W-1:0]  r_in_len;
    logic              cd_v, cv_v, ld_v;
    t_item             cd_item, cv_item;
    logic [TS_W-1:0]   ld_index;
    logic              ld_err;
    logic              r_out_v;
    logic [TS_W-1:0]   r_out_index;
    logic              r_out_err;

    assign busy = 1'b0;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= UNIT_SEC;
            r_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNIT:   r_unit <= i_cfg_data[UNIT_W-1:0];
                CFG_LENGTH: r_len  <= i_cfg_data[LEN_W-1:0];
                default:    r_unit <= r_unit;
            endcase
        end
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_ts   <= i_unix_seconds;
        r_in_unit <= r_unit;
        r_in_len  <= r_len;
    end

    tpi_cdiv u_cdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_v),
        .i_ts     (r_in_ts),
        .i_unit   (r_in_unit),
        .i_length (r_in_len),
        .o_valid  (cd_v),
        .o_item   (cd_item)
    );

    tpi_civil u_civil (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cd_v),
        .i_item   (cd_item),
        .o_valid  (cv_v),
        .o_item   (cv_item)
    );

    tpi_ldiv u_ldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cv_v),
        .i_item   (cv_item),
        .o_valid  (ld_v),
        .o_index  (ld_index),
        .o_error  (ld_err)
    );

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= ld_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_index <= ld_index;
        r_out_err   <= ld_err;
    end

    assign o_valid             = r_out_v;
    assign o_period_index      = r_out_index;
    assign o_zero_length_error = r_out_err;

    // Every accepted word comes out after the fixed latency
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(TOTAL_LAT) o_valid)
        else $error("accepted word not delivered");

    // No result without an accepted word
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without a command");

    // An error result carries a zero index
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length_error |-> o_period_index == '0)
        else $error("nonzero index on zero length");

endmodule

// File: tb/sv/tb_timestamp_to_period_index.sv
`timescale 1ns / 100ps

module tb_timestamp_to_period_index;
    import tpi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = TOTAL_LAT + 10;
    localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

    typedef struct packed {
        logic [TS_W-1:0] index;
        logic            zero_err;
    } t_bucket;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [TS_W-1:0]  i_unix_seconds;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_valid;
    logic [TS_W-1:0]  o_period_index;
    logic             o_zero_length_error;

    // Predictor copy of the configuration
    logic [UNIT_W-1:0] unit_cfg;
    logic [LEN_W-1:0]  length_cfg;

    t_bucket bucket_q[$];
    int      error_count;
    int      idle_cycles;

    timestamp_to_period_index u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_unix_seconds      (i_unix_seconds),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_period_index      (o_period_index),
        .o_zero_length_error (o_zero_length_error)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Civil year and month (1..12) from days since the epoch
    function automatic void days_to_civil(input longint unsigned days,
                                          output longint unsigned yr,
                                          output longint unsigned mon);
        longint unsigned z, era, doe, yoe, doy, mp;
        z   = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        yr  = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    endfunction

    function automatic t_bucket bucket_of(input logic [TS_W-1:0] ts);
        longint unsigned t, cnt, yr, mon;
        t_bucket b;
        t = ts;
        case (unit_cfg)
            UNIT_SEC:   cnt = t;
            UNIT_MIN:   cnt = t / SECS_MIN;
            UNIT_HOUR:  cnt = t / SECS_HOUR;
            UNIT_DAY:   cnt = t / SECS_DAY;
            UNIT_WEEK:  cnt = (t < WEEK_OFS) ? 0 : (t - WEEK_OFS) / SECS_WEEK;
            UNIT_MONTH: begin
                days_to_civil(t / SECS_DAY, yr, mon);
                cnt = MONTHS_YR * (yr - BASE_YEAR) + (mon - 1);
            end
            UNIT_YEAR: begin
                days_to_civil(t / SECS_DAY, yr, mon);
                cnt = yr - BASE_YEAR;
            end
            default:    cnt = 0;
        endcase
        if (length_cfg == 0) begin
            b.index    = '0;
            b.zero_err = 1'b1;
        end else begin
            b.index    = TS_W'(cnt / length_cfg);
            b.zero_err = 1'b0;
        end
        return b;
    endfunction

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_bucket exp_b;
        if (i_rst_n && o_valid) begin
            if (bucket_q.size() == 0) begin
                $display("%0t: unexpected word index=%0d err=%0b", $time,
                         o_period_index, o_zero_length_error);
                error_count++;
            end else begin
                exp_b = bucket_q.pop_front();
                if (o_period_index !== exp_b.index) begin
                    $display("%0t: period_index expected %0d actual %0d", $time,
                             exp_b.index, o_period_index);
                    error_count++;
                end
                if (o_zero_length_error !== exp_b.zero_err) begin
                    $display("%0t: zero_length_error expected %0b actual %0b",
                             $time, exp_b.zero_err, o_zero_length_error);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with nothing accepted and no result out
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sometimes drop start and idle for a random number of cycles
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 99) < 60)
            return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Send one timestamp word and queue its bucket
    task automatic send_ts(input logic [TS_W-1:0] ts, input bit gaps = 1'b1);
        if (gaps)
            idle_gap();
        start          <= 1'b1;
        i_unix_seconds <= ts;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        bucket_q.push_back(bucket_of(ts));
    endtask

    // Let the pipeline drain, then write one register
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        start <= 1'b0;
        while (bucket_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_UNIT)
            unit_cfg = data[UNIT_W-1:0];
        else
            length_cfg = data[LEN_W-1:0];
    endtask

    function automatic logic [TS_W-1:0] rand_ts();
        case ($urandom_range(0, 3))
            0: return TS_W'($urandom_range(0, 3 * SECS_WEEK));
            1: return TS_W'({$urandom, $urandom});
            2: return TS_MAX - TS_W'($urandom_range(0, 100000));
            default: return TS_W'($urandom) + TS_W'(64'($urandom_range(0, 3)) << 32);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_ts('0);
        send_ts(TS_MAX);
        send_ts(TS_W'(64'h2_AAAA_5555));
        send_ts(TS_W'(64'h1_5555_AAAA));
    endtask

    // Every unit, boundaries around the week offset and leap days
    task automatic test_directed_units();
        write_reg(CFG_LENGTH, 16'd1);
        for (int u = 0; u < 8; u++) begin
            write_reg(CFG_UNIT, CFG_W'(u));
            send_ts('0, 1'b0);
            send_ts(TS_W'(WEEK_OFS - 1), 1'b0);
            send_ts(TS_W'(WEEK_OFS), 1'b0);
            send_ts(TS_W'(951782400), 1'b0);
            send_ts(TS_MAX, 1'b0);
        end
    endtask

    task automatic test_length_extremes();
        write_reg(CFG_UNIT, CFG_W'(UNIT_SEC));
        write_reg(CFG_LENGTH, 16'd0);
        send_ts(TS_MAX);
        send_ts(TS_W'(12345));
        write_reg(CFG_LENGTH, 16'hFFFF);
        send_ts(TS_MAX);
        send_ts(TS_W'(65534));
        write_reg(CFG_UNIT, CFG_W'(UNIT_MONTH));
        send_ts(TS_MAX);
    endtask

    // Random phases over random settings, extremes weighted in
    task automatic test_random_phases();
        logic [LEN_W-1:0] len;
        for (int p = 0; p < 24; p++) begin
            write_reg(CFG_UNIT, CFG_W'($urandom_range(0, 7)));
            case ($urandom_range(0, 5))
                0: len = '0;
                1: len = 16'hFFFF;
                2: len = 16'd1;
                3: len = LEN_W'($urandom_range(1, 100));
                default: len = LEN_W'($urandom);
            endcase
            write_reg(CFG_LENGTH, CFG_W'(len));
            for (int k = 0; k < 50; k++)
                send_ts(rand_ts(), (p % 4) != 0);
        end
    endtask

    initial begin
        error_count    = 0;
        idle_cycles    = 0;
        unit_cfg       = UNIT_SEC;
        length_cfg     = 16'd1;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_unix_seconds <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_UNIT;
        i_cfg_data     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_units();
        test_length_extremes();
        test_random_phases();

        start <= 1'b0;
        while (bucket_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
